[rtl/core/pfd_pkg.sv]
// Shared constants and types of the page-layout framebuffer drawing block.
package pfd_pkg;

   localparam int DISPLAY_WIDTH_DEFAULT  = 128;
   localparam int DISPLAY_HEIGHT_DEFAULT = 32;
   localparam int PAGE_ROWS              = 8;

   localparam int MODE_W       = 3;
   localparam int COORD_W      = 8;
   localparam int INDEX_W      = 9;
   localparam int PIXEL_ADDR_W = 11;

   localparam int REQ_FIELDS_W = MODE_W + 4 * COORD_W + INDEX_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W  = 8;

   localparam logic [MODE_W-1:0] MODE_PIXEL = 3'd0;
   localparam logic [MODE_W-1:0] MODE_HLINE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_VLINE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RECT  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

   // The four lines of a rectangle, in drawing order.
   typedef enum logic [1:0] {
      SEG_TOP    = 2'd0,
      SEG_LEFT   = 2'd1,
      SEG_RIGHT  = 2'd2,
      SEG_BOTTOM = 2'd3
   } seg_type;

endpackage

[rtl/core/page_framebuffer_draw.sv]
// Monochrome page-layout framebuffer with pixel, line, rectangle and byte read requests.
//
// Throughput: one request at a time, the next taken the cycle after the response is raised;
// inside it one pixel a cycle through the read-modify-write pipeline, bridged by forwarding.
// Reset: synchronous and active high; afterwards a clearing pass writes zero to all
// DISPLAY_WIDTH * ceil(DISPLAY_HEIGHT / 8) bytes (512 by default), before the first request.
module page_framebuffer_draw #(
   parameter int DISPLAY_WIDTH  = pfd_pkg::DISPLAY_WIDTH_DEFAULT,
   parameter int DISPLAY_HEIGHT = pfd_pkg::DISPLAY_HEIGHT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // From bit 0: mode[3], x_start[8], y_start[8], span_width[8], span_height[8],
   // read_index[9], zero fill[4].
   input  logic [pfd_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // From bit 0: read_data[8].
   output logic [pfd_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + pfd_pkg::PAGE_ROWS - 1) / pfd_pkg::PAGE_ROWS;
   localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
   localparam int ADDR_W      = $clog2(STORE_BYTES);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DRAW,
      ST_READ,
      ST_FINISH
   } state_type;

   // Request fields, unpacked from the bus.
   logic [pfd_pkg::MODE_W-1:0]  req_mode;
   logic [pfd_pkg::COORD_W-1:0] req_x_start;
   logic [pfd_pkg::COORD_W-1:0] req_y_start;
   logic [pfd_pkg::COORD_W-1:0] req_span_width;
   logic [pfd_pkg::COORD_W-1:0] req_span_height;
   logic [pfd_pkg::INDEX_W-1:0] req_read_index;

   assign req_mode        = req_tdata[2:0];
   assign req_x_start     = req_tdata[10:3];
   assign req_y_start     = req_tdata[18:11];
   assign req_span_width  = req_tdata[26:19];
   assign req_span_height = req_tdata[34:27];
   assign req_read_index  = req_tdata[43:35];

   // Control state.
   state_type                   state_ff, state_in;
   logic [ADDR_W-1:0]           clr_addr_ff, clr_addr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        read_ok_ff, read_ok_in;
   logic                        s1_valid_ff, s1_valid_in;
   logic                        last_wr_valid_ff, last_wr_valid_in;

   // Request payload held for the duration of the request.
   logic [pfd_pkg::COORD_W-1:0] x_ff, x_in;
   logic [pfd_pkg::COORD_W-1:0] y_ff, y_in;
   logic [pfd_pkg::COORD_W-1:0] w_ff, w_in;
   logic [pfd_pkg::COORD_W-1:0] h_ff, h_in;
   logic                        point_ff, point_in;
   logic [ADDR_W-1:0]           read_addr_ff, read_addr_in;
   pfd_pkg::seg_type            seg_ff, seg_in;
   pfd_pkg::seg_type            seg_end_ff, seg_end_in;
   logic [pfd_pkg::COORD_W-1:0] cnt_ff, cnt_in;
   logic [pfd_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Read-modify-write pipeline: the pixel whose byte was read last cycle, and the last write.
   logic [ADDR_W-1:0]           s1_addr_ff, s1_addr_in;
   logic [7:0]                  s1_mask_ff, s1_mask_in;
   logic [ADDR_W-1:0]           last_wr_addr_ff, last_wr_addr_in;
   logic [7:0]                  last_wr_data_ff, last_wr_data_in;

   // Framebuffer memory.
   logic [7:0]                  frame_mem [STORE_BYTES];
   logic [7:0]                  rdata_ff;
   logic                        mem_rd_en;
   logic [ADDR_W-1:0]           mem_rd_addr;
   logic                        mem_wr_en;
   logic [ADDR_W-1:0]           mem_wr_addr;
   logic [7:0]                  mem_wr_data;

   // Current line segment and pixel.
   logic [pfd_pkg::COORD_W-1:0] seg_x;
   logic [pfd_pkg::COORD_W-1:0] seg_y;
   logic                        seg_horiz;
   logic [pfd_pkg::COORD_W-1:0] seg_len;
   logic [pfd_pkg::COORD_W-1:0] pix_x;
   logic [pfd_pkg::COORD_W-1:0] pix_y;
   logic                        pix_on_screen;
   logic [pfd_pkg::PIXEL_ADDR_W-1:0] pix_addr_wide;
   logic [pfd_pkg::PIXEL_ADDR_W-1:0] read_index_wide;
   logic [7:0]                  rmw_base;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A rectangle is two horizontal and two vertical lines; the right and bottom edges sit at
   // the wrapped far coordinates. A single pixel is a horizontal line of length one.
   always_comb begin
      seg_x     = x_ff;
      seg_y     = y_ff;
      seg_horiz = 1'b1;
      seg_len   = point_ff ? 8'd1 : w_ff;
      case (seg_ff)
         pfd_pkg::SEG_TOP: begin
            seg_horiz = 1'b1;
         end
         pfd_pkg::SEG_LEFT: begin
            seg_horiz = 1'b0;
            seg_len   = h_ff;
         end
         pfd_pkg::SEG_RIGHT: begin
            seg_x     = x_ff + w_ff - 8'd1;
            seg_horiz = 1'b0;
            seg_len   = h_ff;
         end
         pfd_pkg::SEG_BOTTOM: begin
            seg_y     = y_ff + h_ff - 8'd1;
            seg_horiz = 1'b1;
         end
         default: begin
            seg_horiz = 1'b1;
         end
      endcase
   end

   assign pix_x = seg_horiz ? (seg_x + cnt_ff) : seg_x;
   assign pix_y = seg_horiz ? seg_y : (seg_y + cnt_ff);

   assign pix_on_screen = (9'(pix_x) < 9'(DISPLAY_WIDTH)) && (9'(pix_y) < 9'(DISPLAY_HEIGHT));

   // Byte index x + (y / 8) * width; the page number is five bits (y[7:3]), times a constant.
   assign pix_addr_wide = pfd_pkg::PIXEL_ADDR_W'(pix_x)
                        + pfd_pkg::PIXEL_ADDR_W'(pix_y[7:3])
                        * pfd_pkg::PIXEL_ADDR_W'(DISPLAY_WIDTH);

   assign read_index_wide = pfd_pkg::PIXEL_ADDR_W'(req_read_index);

   // The byte written last cycle is not yet in the read data, so it is taken from the
   // write register when the addresses match.
   assign rmw_base = (last_wr_valid_ff && (last_wr_addr_ff == s1_addr_ff))
                   ? last_wr_data_ff : rdata_ff;

   always_comb begin
      state_in         = state_ff;
      clr_addr_in      = clr_addr_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;
      read_ok_in       = read_ok_ff;
      x_in             = x_ff;
      y_in             = y_ff;
      w_in             = w_ff;
      h_in             = h_ff;
      point_in         = point_ff;
      read_addr_in     = read_addr_ff;
      seg_in           = seg_ff;
      seg_end_in       = seg_end_ff;
      cnt_in           = cnt_ff;
      s1_valid_in      = 1'b0;
      s1_addr_in       = ADDR_W'(pix_addr_wide);
      s1_mask_in       = 8'(1) << pix_y[2:0];
      mem_rd_en        = 1'b0;
      mem_rd_addr      = ADDR_W'(pix_addr_wide);
      mem_wr_en        = 1'b0;
      mem_wr_addr      = s1_addr_ff;
      mem_wr_data      = rmw_base | s1_mask_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Second half of the read-modify-write: the byte read last cycle goes back with the bit.
      if (s1_valid_ff) begin
         mem_wr_en = 1'b1;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_data = 8'd0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in         = req_x_start;
               y_in         = req_y_start;
               w_in         = req_span_width;
               h_in         = req_span_height;
               point_in     = (req_mode == pfd_pkg::MODE_PIXEL);
               read_addr_in = ADDR_W'(read_index_wide);
               read_ok_in   = 1'b0;
               cnt_in       = 8'd0;
               seg_in       = pfd_pkg::SEG_TOP;
               seg_end_in   = pfd_pkg::SEG_TOP;
               case (req_mode)
                  pfd_pkg::MODE_PIXEL, pfd_pkg::MODE_HLINE: begin
                     state_in = ST_DRAW;
                  end
                  pfd_pkg::MODE_VLINE: begin
                     seg_in     = pfd_pkg::SEG_LEFT;
                     seg_end_in = pfd_pkg::SEG_LEFT;
                     state_in   = ST_DRAW;
                  end
                  pfd_pkg::MODE_RECT: begin
                     seg_end_in = pfd_pkg::SEG_BOTTOM;
                     state_in   = ST_DRAW;
                  end
                  pfd_pkg::MODE_READ: begin
                     read_ok_in = (read_index_wide < pfd_pkg::PIXEL_ADDR_W'(STORE_BYTES));
                     state_in   = ST_READ;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_DRAW: begin
            // One pixel of the current line a cycle; an empty line only moves on.
            if (seg_len != 8'd0 && pix_on_screen) begin
               mem_rd_en   = 1'b1;
               s1_valid_in = 1'b1;
            end
            if (seg_len == 8'd0 || cnt_ff == seg_len - 8'd1) begin
               cnt_in = 8'd0;
               if (seg_ff == seg_end_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  seg_in = pfd_pkg::seg_type'(seg_ff + 2'd1);
               end
            end else begin
               cnt_in = cnt_ff + 8'd1;
            end
         end
         ST_READ: begin
            // Every earlier write has reached the memory by now.
            mem_rd_en   = 1'b1;
            mem_rd_addr = read_addr_ff;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            // The last pixel is written in the first cycle here; the result waits for a free slot.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = read_ok_ff ? rdata_ff : 8'd0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      last_wr_valid_in = mem_wr_en;
      last_wr_addr_in  = mem_wr_addr;
      last_wr_data_in  = mem_wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_addr_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
         rsp_data_ff      <= '0;
         read_ok_ff       <= 1'b0;
         s1_valid_ff      <= 1'b0;
         last_wr_valid_ff <= 1'b0;
         seg_ff           <= pfd_pkg::SEG_TOP;
         seg_end_ff       <= pfd_pkg::SEG_TOP;
         cnt_ff           <= '0;
      end else begin
         state_ff         <= state_in;
         clr_addr_ff      <= clr_addr_in;
         rsp_valid_ff     <= rsp_valid_in;
         rsp_data_ff      <= rsp_data_in;
         read_ok_ff       <= read_ok_in;
         s1_valid_ff      <= s1_valid_in;
         last_wr_valid_ff <= last_wr_valid_in;
         seg_ff           <= seg_in;
         seg_end_ff       <= seg_end_in;
         cnt_ff           <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff            <= x_in;
      y_ff            <= y_in;
      w_ff            <= w_in;
      h_ff            <= h_in;
      point_ff        <= point_in;
      read_addr_ff    <= read_addr_in;
      s1_addr_ff      <= s1_addr_in;
      s1_mask_ff      <= s1_mask_in;
      last_wr_addr_ff <= last_wr_addr_in;
      last_wr_data_ff <= last_wr_data_in;
   end

   // Simple dual-port memory: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         frame_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rdata_ff <= frame_mem[mem_rd_addr];
      end
   end

endmodule
